### sv/sequenced_jitter_buffer_assert.svh
// Assertion macros shared by the checker of the jitter buffer.
`ifndef SEQUENCED_JITTER_BUFFER_ASSERT_SVH
`define SEQUENCED_JITTER_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SJB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define SJB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sjb_pkg.sv
// Shared constants, types and helper functions of the jitter buffer.
package sjb_pkg;

    localparam int CAPACITY    = 64;
    localparam int MISS_LIMIT  = 40;
    localparam int HANDLE_BITS = 16;
    localparam int SEQ_W       = 32;
    localparam int EPI_W       = 32;
    localparam int CFG_W       = 7;
    localparam int OUT_CNT_W   = 7;
    localparam int CFG_IDX_W   = 1;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int DROP_W = $clog2(CAPACITY + 2);
    localparam int MISS_W = $clog2(MISS_LIMIT + 1);
    localparam int WIDE_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

    // Divide by ten as multiply by reciprocal; exact for counts up to 1023.
    localparam int MARGIN_DIV  = 10;
    localparam int RECIP_SHIFT = 11;
    localparam int RECIP_MUL   = (1 << RECIP_SHIFT) / MARGIN_DIV + 1;
    localparam int PROD_W      = CNT_W + 8;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FILL  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_CEILING = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MATCH,
        ST_DECIDE,
        ST_KILL,
        ST_INSERT,
        ST_START,
        ST_LOOKUP,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_PUSH,
        CAP_CHECK
    } t_cap_op;

    typedef struct packed {
        logic                   valid;
        logic [SEQ_W-1:0]       seq;
        logic [HANDLE_BITS-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic [CNT_W-1:0] target;
        logic [CNT_W-1:0] ceil;
        logic [CNT_W-1:0] thr;
    } t_limits;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_ring_cmd;

    // Fill at or below this level ends a cap episode.
    function automatic logic [CNT_W-1:0] recover_thr(input logic [CNT_W-1:0] c);
        logic [PROD_W-1:0] prod;
        logic [CNT_W-1:0]  margin;
        prod   = PROD_W'(c) * PROD_W'(RECIP_MUL);
        margin = CNT_W'(prod >> RECIP_SHIFT);
        if (margin == '0) begin
            margin = CNT_W'(1);
        end
        return (margin < c) ? (c - margin) : '0;
    endfunction

endpackage

### sv/sjb_cell.sv
// One storage cell of the rotating entry ring.
module sjb_cell
    import sjb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ring_cmd i_cmd,
    input  t_entry    i_d,
    output t_entry    o_q
);

    logic                   r_valid;
    logic [SEQ_W-1:0]       r_seq;
    logic [HANDLE_BITS-1:0] r_handle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.clear) begin
            r_valid <= 1'b0;
        end else if (i_cmd.shift) begin
            r_valid <= i_d.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_seq    <= i_d.seq;
            r_handle <= i_d.handle;
        end
    end

    assign o_q = '{valid: r_valid, seq: r_seq, handle: r_handle};

endmodule

### sv/sjb_ctrl.sv
// Sequencer of the jitter buffer: head-cell operations, counters and result register.
module sjb_ctrl
    import sjb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_func,
    input  logic [SEQ_W-1:0]       i_seq_num,
    input  logic [HANDLE_BITS-1:0] i_frame_handle,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_frame_valid,
    output logic [HANDLE_BITS-1:0] o_out_handle,
    output logic [OUT_CNT_W-1:0]   o_dropped_count,
    output logic                   o_at_cap,
    output logic [EPI_W-1:0]       o_cap_episode_count,
    output logic [OUT_CNT_W-1:0]   o_fill_level,
    input  t_limits                i_lim,
    input  t_entry                 i_head,
    output t_entry                 o_wb,
    output t_ring_cmd              o_cmd
);

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_cnt, n_cnt;
    logic [SEQ_W-1:0]       r_seq, n_seq;
    logic [HANDLE_BITS-1:0] r_handle, n_handle;
    logic                   r_fast, n_fast;
    logic                   r_pending, n_pending;
    logic                   r_ins_done, n_ins_done;
    logic                   r_hit, n_hit;
    logic [SEQ_W-1:0]       r_kill_seq, n_kill_seq;
    logic                   r_min_any, n_min_any;
    logic [SEQ_W-1:0]       r_min_seq, n_min_seq;
    logic [CNT_W-1:0]       r_fill, n_fill;
    logic [DROP_W-1:0]      r_dropped, n_dropped;
    logic                   r_playing, n_playing;
    logic [SEQ_W-1:0]       r_exp, n_exp;
    logic [MISS_W-1:0]      r_miss, n_miss;
    logic                   r_cap_flag, n_cap_flag;
    logic [EPI_W-1:0]       r_episodes, n_episodes;
    t_cap_op                r_cap_op, n_cap_op;
    logic                   r_res_valid, n_res_valid;
    logic [HANDLE_BITS-1:0] r_res_handle, n_res_handle;

    logic                   r_out_valid, n_out_valid;
    logic                   r_out_frame, n_out_frame;
    logic [HANDLE_BITS-1:0] r_out_handle, n_out_handle;
    logic [OUT_CNT_W-1:0]   r_out_dropped, n_out_dropped;
    logic                   r_out_cap, n_out_cap;
    logic [EPI_W-1:0]       r_out_epi, n_out_epi;
    logic [OUT_CNT_W-1:0]   r_out_fill, n_out_fill;

    logic              accept;
    logic              in_pass;
    logic              pass_end;
    logic              head_is_seq;
    logic              head_is_kill;
    logic              head_is_exp;
    logic              late;
    logic              can_start;
    logic [CNT_W:0]    total;
    logic              evict;
    logic              take_new;
    logic [SEQ_W-1:0]  oldest;
    logic              out_free;
    logic              lookup_hit;
    logic [MISS_W-1:0] miss_inc;
    logic              recover;
    logic              cap_flag_upd;
    logic [EPI_W-1:0]  episodes_upd;
    t_entry            wb;

    assign accept       = i_in_valid && (r_state == ST_IDLE);
    assign in_pass      = (r_state == ST_MATCH) || (r_state == ST_KILL) ||
                          (r_state == ST_INSERT) || (r_state == ST_START) ||
                          (r_state == ST_LOOKUP);
    assign pass_end     = in_pass && (r_cnt == IDX_W'(CAPACITY - 1));
    assign head_is_seq  = i_head.valid && (i_head.seq == r_seq);
    assign head_is_kill = i_head.valid && (i_head.seq == r_kill_seq);
    assign head_is_exp  = i_head.valid && (i_head.seq == r_exp);
    assign late         = r_playing && (i_seq_num < r_exp);
    assign can_start    = (r_fill != '0) && (r_fill >= i_lim.target);
    assign total        = {1'b0, r_fill} + (CNT_W + 1)'(r_pending);
    assign evict        = total > {1'b0, i_lim.ceil};
    assign take_new     = r_pending && (!r_min_any || (r_seq < r_min_seq));
    assign oldest       = take_new ? r_seq : r_min_seq;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign lookup_hit   = r_hit || head_is_exp;
    assign miss_inc     = r_miss + MISS_W'(1);
    assign recover      = r_fill <= i_lim.thr;

    // Cap episode update applied when the result is written out.
    always_comb begin
        cap_flag_upd = r_cap_flag;
        episodes_upd = r_episodes;
        case (r_cap_op)
            CAP_PUSH: begin
                if (r_dropped != '0) begin
                    if (!r_cap_flag) begin
                        cap_flag_upd = 1'b1;
                        episodes_upd = r_episodes + EPI_W'(1);
                    end
                end else if (recover) begin
                    cap_flag_upd = 1'b0;
                end
            end
            CAP_CHECK: begin
                if (recover) begin
                    cap_flag_upd = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_func == FUNC_POP) begin
                        if (r_playing) begin
                            n_state = ST_LOOKUP;
                        end else if (can_start) begin
                            n_state = ST_START;
                        end else begin
                            n_state = ST_FINISH;
                        end
                    end else if (late) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_MATCH;
                    end
                end
            end
            ST_MATCH: begin
                if (pass_end) begin
                    n_state = r_fast ? ST_FINISH : ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (evict) begin
                    n_state = take_new ? ST_DECIDE : ST_KILL;
                end else begin
                    n_state = r_pending ? ST_INSERT : ST_FINISH;
                end
            end
            ST_KILL: begin
                if (pass_end) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_INSERT: begin
                if (pass_end) begin
                    n_state = ST_FINISH;
                end
            end
            ST_START: begin
                if (pass_end) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (pass_end) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_cnt         = (in_pass && !pass_end) ? (r_cnt + IDX_W'(1)) : '0;
        n_seq         = r_seq;
        n_handle      = r_handle;
        n_fast        = r_fast;
        n_pending     = r_pending;
        n_ins_done    = r_ins_done;
        n_hit         = r_hit;
        n_kill_seq    = r_kill_seq;
        n_min_any     = r_min_any;
        n_min_seq     = r_min_seq;
        n_fill        = r_fill;
        n_dropped     = r_dropped;
        n_playing     = r_playing;
        n_exp         = r_exp;
        n_miss        = r_miss;
        n_cap_flag    = r_cap_flag;
        n_episodes    = r_episodes;
        n_cap_op      = r_cap_op;
        n_res_valid   = r_res_valid;
        n_res_handle  = r_res_handle;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_frame   = r_out_frame;
        n_out_handle  = r_out_handle;
        n_out_dropped = r_out_dropped;
        n_out_cap     = r_out_cap;
        n_out_epi     = r_out_epi;
        n_out_fill    = r_out_fill;
        wb            = i_head;
        o_cmd.shift   = in_pass;
        o_cmd.clear   = 1'b0;
        o_in_stall    = (r_state != ST_IDLE);

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_seq        = i_seq_num;
                    n_handle     = i_frame_handle;
                    n_fast       = r_fill < i_lim.ceil;
                    n_pending    = 1'b1;
                    n_ins_done   = 1'b0;
                    n_hit        = 1'b0;
                    n_min_any    = 1'b0;
                    n_dropped    = '0;
                    n_res_valid  = 1'b0;
                    n_res_handle = '0;
                    n_cap_op     = CAP_NONE;
                    if ((i_func == FUNC_PUSH) && !late) begin
                        n_cap_op = CAP_PUSH;
                    end
                end
            end
            ST_MATCH: begin
                // Fast path inserts at the first free cell; a later copy of the
                // same number is dropped so the new word survives.
                if (head_is_seq) begin
                    if (r_fast && r_ins_done) begin
                        wb.valid = 1'b0;
                        n_fill   = r_fill - CNT_W'(1);
                    end else begin
                        wb.handle = r_handle;
                        n_pending = 1'b0;
                    end
                end else if (r_fast && !i_head.valid && r_pending && !r_ins_done) begin
                    wb         = '{valid: 1'b1, seq: r_seq, handle: r_handle};
                    n_ins_done = 1'b1;
                    n_fill     = r_fill + CNT_W'(1);
                end
            end
            ST_DECIDE: begin
                if (evict) begin
                    n_dropped = r_dropped + DROP_W'(1);
                    if (r_playing && (oldest >= r_exp)) begin
                        n_exp = oldest + SEQ_W'(1);
                    end
                    if (take_new) begin
                        n_pending = 1'b0;
                    end else begin
                        n_kill_seq = r_min_seq;
                        n_min_any  = 1'b0;
                    end
                end
            end
            ST_KILL: begin
                if (head_is_kill) begin
                    wb.valid = 1'b0;
                    n_fill   = r_fill - CNT_W'(1);
                end
            end
            ST_INSERT: begin
                if (!i_head.valid && r_pending) begin
                    wb        = '{valid: 1'b1, seq: r_seq, handle: r_handle};
                    n_pending = 1'b0;
                    n_fill    = r_fill + CNT_W'(1);
                end
            end
            ST_LOOKUP: begin
                if (head_is_exp) begin
                    wb.valid     = 1'b0;
                    n_fill       = r_fill - CNT_W'(1);
                    n_res_valid  = 1'b1;
                    n_res_handle = i_head.handle;
                    n_hit        = 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_cap_flag    = cap_flag_upd;
                    n_episodes    = episodes_upd;
                    n_out_valid   = 1'b1;
                    n_out_frame   = r_res_valid;
                    n_out_handle  = r_res_handle;
                    n_out_dropped = OUT_CNT_W'(r_dropped);
                    n_out_cap     = cap_flag_upd;
                    n_out_epi     = episodes_upd;
                    n_out_fill    = OUT_CNT_W'(r_fill);
                end
            end
            default: begin
            end
        endcase

        // Track the smallest stored number over the passes that need it.
        if (((r_state == ST_MATCH) || (r_state == ST_KILL) || (r_state == ST_START)) &&
            wb.valid && (!r_min_any || (wb.seq < r_min_seq))) begin
            n_min_any = 1'b1;
            n_min_seq = wb.seq;
        end

        if (pass_end) begin
            case (r_state)
                ST_START: begin
                    n_playing = 1'b1;
                    n_exp     = n_min_seq;
                    n_miss    = '0;
                end
                ST_LOOKUP: begin
                    n_exp = r_exp + SEQ_W'(1);
                    if (lookup_hit) begin
                        n_miss   = '0;
                        n_cap_op = CAP_CHECK;
                    end else if (miss_inc >= MISS_W'(MISS_LIMIT)) begin
                        // Too many misses in a row: flush and refill.
                        n_playing   = 1'b0;
                        n_miss      = '0;
                        o_cmd.clear = 1'b1;
                        n_fill      = '0;
                        n_cap_op    = CAP_CHECK;
                    end else begin
                        n_miss = miss_inc;
                    end
                end
                default: begin
                end
            endcase
        end

        o_wb = wb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_fill      <= '0;
            r_playing   <= 1'b0;
            r_exp       <= '0;
            r_miss      <= '0;
            r_cap_flag  <= 1'b0;
            r_episodes  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_fill      <= n_fill;
            r_playing   <= n_playing;
            r_exp       <= n_exp;
            r_miss      <= n_miss;
            r_cap_flag  <= n_cap_flag;
            r_episodes  <= n_episodes;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq         <= n_seq;
        r_handle      <= n_handle;
        r_fast        <= n_fast;
        r_pending     <= n_pending;
        r_ins_done    <= n_ins_done;
        r_hit         <= n_hit;
        r_kill_seq    <= n_kill_seq;
        r_min_any     <= n_min_any;
        r_min_seq     <= n_min_seq;
        r_dropped     <= n_dropped;
        r_cap_op      <= n_cap_op;
        r_res_valid   <= n_res_valid;
        r_res_handle  <= n_res_handle;
        r_out_frame   <= n_out_frame;
        r_out_handle  <= n_out_handle;
        r_out_dropped <= n_out_dropped;
        r_out_cap     <= n_out_cap;
        r_out_epi     <= n_out_epi;
        r_out_fill    <= n_out_fill;
    end

    assign o_out_valid         = r_out_valid;
    assign o_frame_valid       = r_out_frame;
    assign o_out_handle        = r_out_handle;
    assign o_dropped_count     = r_out_dropped;
    assign o_at_cap            = r_out_cap;
    assign o_cap_episode_count = r_out_epi;
    assign o_fill_level        = r_out_fill;

endmodule

### sv/sequenced_jitter_buffer.sv
// Top level of the sequenced jitter buffer: config registers, entry ring and sequencer.
//
// Frames are held as (sequence number, handle) pairs in a ring of 64 cells that rotates
// one position per clock during each pass over the ring; the sequencer sees and edits
// only the head cell, so every lookup, insert, eviction of a stored entry and minimum
// search is one full revolution. One item is worked on at a time. Per item, a push with
// the fill below the ceiling takes one match revolution; a push at or over it takes a
// search revolution, a decision step before each eviction and after the last, a kill
// revolution per evicted stored entry and an insert revolution if still pending; a late
// push and a pop before playback starts finish directly; a pop during playback takes a
// lookup revolution, and the pop that starts playback a start and then a lookup
// revolution. After a run of 40 missed pops the whole ring is flushed, all cells cleared
// together as that lookup ends. The input stalls while an item is in flight; a finished
// result waits in the output register, so the next word is taken as soon as the previous
// result is parked there. Configuration writes are always ready and take effect at once;
// write them only while no item is in flight.
module sequenced_jitter_buffer
    import sjb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_func,
    input  logic [SEQ_W-1:0]       i_seq_num,
    input  logic [HANDLE_BITS-1:0] i_frame_handle,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_frame_valid,
    output logic [HANDLE_BITS-1:0] o_out_handle,
    output logic [OUT_CNT_W-1:0]   o_dropped_count,
    output logic                   o_at_cap,
    output logic [EPI_W-1:0]       o_cap_episode_count,
    output logic [OUT_CNT_W-1:0]   o_fill_level,
    // configuration write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    logic [CFG_W-1:0]  r_target_fill;
    logic [CFG_W-1:0]  r_fill_ceiling;
    logic [WIDE_W-1:0] tgt_w;
    logic [WIDE_W-1:0] ceil_w;
    logic [WIDE_W-1:0] cap_w;
    t_limits           lim;
    t_entry            wb;
    t_ring_cmd         cmd;
    t_entry            ring_q [CAPACITY];
    t_entry            ring_d [CAPACITY];

    assign o_cfg_ready = 1'b1;

    // Register file: target fill resets to 8, ceiling to 64.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_fill  <= CFG_W'(8);
            r_fill_ceiling <= CFG_W'(64);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TARGET_FILL: begin
                    r_target_fill <= i_cfg_data;
                end
                CFG_FILL_CEILING: begin
                    r_fill_ceiling <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Effective limits: ceiling is raised to the target, both saturate at capacity.
    always_comb begin
        tgt_w      = WIDE_W'(r_target_fill);
        ceil_w     = WIDE_W'((r_fill_ceiling < r_target_fill) ? r_target_fill
                                                              : r_fill_ceiling);
        cap_w      = WIDE_W'(CAPACITY);
        lim.target = CNT_W'((tgt_w > cap_w) ? cap_w : tgt_w);
        lim.ceil   = CNT_W'((ceil_w > cap_w) ? cap_w : ceil_w);
        lim.thr    = recover_thr(lim.ceil);
    end

    // Ring: each cell takes its neighbor's entry; the last cell takes the edited head.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_ring
        if (k == CAPACITY - 1) begin : g_tail
            assign ring_d[k] = wb;
        end else begin : g_link
            assign ring_d[k] = ring_q[k+1];
        end

        sjb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_d     (ring_d[k]),
            .o_q     (ring_q[k])
        );
    end

    sjb_ctrl u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_func              (i_func),
        .i_seq_num           (i_seq_num),
        .i_frame_handle      (i_frame_handle),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_frame_valid       (o_frame_valid),
        .o_out_handle        (o_out_handle),
        .o_dropped_count     (o_dropped_count),
        .o_at_cap            (o_at_cap),
        .o_cap_episode_count (o_cap_episode_count),
        .o_fill_level        (o_fill_level),
        .i_lim               (lim),
        .i_head              (ring_q[0]),
        .o_wb                (wb),
        .o_cmd               (cmd)
    );

endmodule

### sv/sjb_checker.sv
// Port-level checker of the jitter buffer and its bind to the top level.
`include "sequenced_jitter_buffer_assert.svh"

module sjb_checker
    import sjb_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   i_func,
    input logic [SEQ_W-1:0]       i_seq_num,
    input logic [HANDLE_BITS-1:0] i_frame_handle,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic                   o_frame_valid,
    input logic [HANDLE_BITS-1:0] o_out_handle,
    input logic [OUT_CNT_W-1:0]   o_dropped_count,
    input logic                   o_at_cap,
    input logic [EPI_W-1:0]       o_cap_episode_count,
    input logic [OUT_CNT_W-1:0]   o_fill_level,
    input logic                   i_cfg_valid,
    input logic                   o_cfg_ready,
    input logic [CFG_IDX_W-1:0]   i_cfg_index,
    input logic [CFG_W-1:0]       i_cfg_data
);

    // Only one item is in flight: an accepted word stalls the input next cycle.
    `SJB_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input accepted while an item is in flight")

    // A parked result holds until taken.
    `SJB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_handle) && $stable(o_fill_level) && $stable(o_cap_episode_count), "stalled result changed")

    // Any eviction leaves the cap flag set.
    `SJB_ASSERT_IMPLY(a_drop_sets_cap, i_clk, i_rst_n, o_out_valid && (o_dropped_count != '0), o_at_cap, "eviction without cap flag")

    // Silence and push results carry a zero handle.
    `SJB_ASSERT_IMPLY(a_silence_zero, i_clk, i_rst_n, o_out_valid && !o_frame_valid, o_out_handle == '0, "nonzero handle without frame")

endmodule

bind sequenced_jitter_buffer sjb_checker u_sjb_checker (.*);

### dv/sequenced_jitter_buffer_check.sv
// Checker for the sequenced jitter buffer: playout predictor and result comparison.
module sequenced_jitter_buffer_check
    import sjb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic                   i_func,
    input  logic [SEQ_W-1:0]       i_seq_num,
    input  logic [HANDLE_BITS-1:0] i_frame_handle,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic                   i_frame_valid,
    input  logic [HANDLE_BITS-1:0] i_out_handle,
    input  logic [OUT_CNT_W-1:0]   i_dropped_count,
    input  logic                   i_at_cap,
    input  logic [EPI_W-1:0]       i_cap_episode_count,
    input  logic [OUT_CNT_W-1:0]   i_fill_level,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output int                     o_mismatches,
    output int                     o_outstanding
);

    typedef struct packed {
        logic                   frame_valid;
        logic [HANDLE_BITS-1:0] handle;
        logic [OUT_CNT_W-1:0]   dropped;
        logic                   at_cap;
        logic [EPI_W-1:0]       episodes;
        logic [OUT_CNT_W-1:0]   fill;
    } t_playout;

    logic [SEQ_W-1:0]       slot_seq    [CAPACITY];
    logic [HANDLE_BITS-1:0] slot_handle [CAPACITY];
    bit                     slot_used   [CAPACITY];
    bit                     playing;
    logic [SEQ_W-1:0]       next_seq;
    int                     miss_run;
    bit                     cap_flag;
    logic [EPI_W-1:0]       cap_count;
    int                     target_reg;
    int                     ceiling_reg;
    t_playout               playout_q [$];

    function automatic int held();
        int n;
        n = 0;
        foreach (slot_used[i]) if (slot_used[i]) n++;
        return n;
    endfunction

    function automatic int start_level();
        return (target_reg > CAPACITY) ? CAPACITY : target_reg;
    endfunction

    // Ceiling is never below the target and never above the store size.
    function automatic int cap_level();
        int c;
        c = (ceiling_reg < target_reg) ? target_reg : ceiling_reg;
        return (c > CAPACITY) ? CAPACITY : c;
    endfunction

    function automatic int slot_of(logic [SEQ_W-1:0] s);
        foreach (slot_used[i]) if (slot_used[i] && slot_seq[i] == s) return i;
        return -1;
    endfunction

    // Clear the cap flag once the fill is a tenth (at least one) under the ceiling.
    function automatic void end_cap_episode();
        int c;
        int margin;
        int floor_lvl;
        c = cap_level();
        margin = c / 10;
        if (margin < 1) margin = 1;
        floor_lvl = (margin < c) ? c - margin : 0;
        if (cap_flag && held() <= floor_lvl) cap_flag = 0;
    endfunction

    function automatic t_playout report(logic fv, logic [HANDLE_BITS-1:0] h, int dropped);
        t_playout w;
        w.frame_valid = fv;
        w.handle      = fv ? h : '0;
        w.dropped     = OUT_CNT_W'(dropped);
        w.at_cap      = cap_flag;
        w.episodes    = cap_count;
        w.fill        = OUT_CNT_W'(held());
        return w;
    endfunction

    function automatic t_playout store_frame(logic [SEQ_W-1:0] s, logic [HANDLE_BITS-1:0] h);
        int               hit;
        int               best;
        int               total;
        int               dropped;
        bit               pending;
        bit               take_new;
        logic [SEQ_W-1:0] low_seq;
        logic [SEQ_W-1:0] oldest;
        if (playing && s < next_seq) return report(1'b0, '0, 0);
        hit = slot_of(s);
        pending = (hit < 0);
        if (!pending) slot_handle[hit] = h;
        total = held() + (pending ? 1 : 0);
        dropped = 0;
        // Evict smallest numbers first; the newcomer competes too.
        while (total > cap_level()) begin
            best = -1;
            low_seq = '0;
            foreach (slot_used[i]) begin
                if (slot_used[i] && (best < 0 || slot_seq[i] < low_seq)) begin
                    best = i;
                    low_seq = slot_seq[i];
                end
            end
            take_new = pending && (best < 0 || s < low_seq);
            oldest = take_new ? s : low_seq;
            if (playing && oldest >= next_seq) next_seq = oldest + 1;
            if (take_new) pending = 0;
            else slot_used[best] = 0;
            total--;
            dropped++;
        end
        if (pending) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (!slot_used[i]) begin
                    slot_used[i] = 1;
                    slot_seq[i] = s;
                    slot_handle[i] = h;
                    break;
                end
            end
        end
        if (dropped > 0) begin
            if (!cap_flag) begin
                cap_flag = 1;
                cap_count++;
            end
        end else begin
            end_cap_episode();
        end
        return report(1'b0, '0, dropped);
    endfunction

    function automatic t_playout play_next();
        int                     n;
        int                     at;
        bit                     any;
        logic [SEQ_W-1:0]       low_seq;
        logic [HANDLE_BITS-1:0] h;
        if (!playing) begin
            n = held();
            if (n == 0 || n < start_level()) return report(1'b0, '0, 0);
            any = 0;
            low_seq = '0;
            foreach (slot_used[i]) begin
                if (slot_used[i] && (!any || slot_seq[i] < low_seq)) begin
                    low_seq = slot_seq[i];
                    any = 1;
                end
            end
            playing = 1;
            next_seq = low_seq;
            miss_run = 0;
        end
        at = slot_of(next_seq);
        next_seq++;
        if (at < 0) begin
            miss_run++;
            if (miss_run >= MISS_LIMIT) begin
                playing = 0;
                miss_run = 0;
                foreach (slot_used[i]) slot_used[i] = 0;
                end_cap_episode();
            end
            return report(1'b0, '0, 0);
        end
        miss_run = 0;
        h = slot_handle[at];
        slot_used[at] = 0;
        end_cap_episode();
        return report(1'b1, h, 0);
    endfunction

    function automatic void check_field(string field, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            o_mismatches++;
            if (o_mismatches <= 100)
                $display("%0t: %s expected %0h got %0h", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_playout want;
        if (!i_rst_n) begin
            foreach (slot_used[i]) slot_used[i] = 0;
            playing = 0;
            next_seq = '0;
            miss_run = 0;
            cap_flag = 0;
            cap_count = '0;
            target_reg = 8;
            ceiling_reg = 64;
            playout_q.delete();
            o_mismatches = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_TARGET_FILL) target_reg = i_cfg_data;
                else if (i_cfg_index == CFG_FILL_CEILING) ceiling_reg = i_cfg_data;
            end
            // Compare before queuing, so a word taken this edge never matches itself.
            if (i_out_valid && !i_out_stall) begin
                if (playout_q.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: result word expected none got fill %0d handle %0h",
                             $time, i_fill_level, i_out_handle);
                end else begin
                    want = playout_q.pop_front();
                    check_field("frame_valid", want.frame_valid, i_frame_valid);
                    check_field("out_handle", want.handle, i_out_handle);
                    check_field("dropped_count", want.dropped, i_dropped_count);
                    check_field("at_cap", want.at_cap, i_at_cap);
                    check_field("cap_episode_count", want.episodes, i_cap_episode_count);
                    check_field("fill_level", want.fill, i_fill_level);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_func == FUNC_POP) playout_q.push_back(play_next());
                else playout_q.push_back(store_frame(i_seq_num, i_frame_handle));
            end
        end
        o_outstanding <= playout_q.size();
    end

endmodule

### dv/sequenced_jitter_buffer_test.sv
// Testbench top of the sequenced jitter buffer: clock, reset, stimulus and verdict.
module sequenced_jitter_buffer_test;
    import sjb_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   func;
    logic [SEQ_W-1:0]       seq_num;
    logic [HANDLE_BITS-1:0] frame_handle;
    logic                   out_valid;
    logic                   out_stall;
    logic                   frame_valid;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [OUT_CNT_W-1:0]   dropped_count;
    logic                   at_cap;
    logic [EPI_W-1:0]       cap_episode_count;
    logic [OUT_CNT_W-1:0]   fill_level;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    int                     mismatches;
    int                     outstanding;

    // Shared between the stimulus and the result-side process.
    int                     hold_cycles_req = 0;
    bit                     tx_quiet = 0;
    bit                     rx_quiet = 0;
    // Next in-order sequence number of the simulated packet stream.
    logic [SEQ_W-1:0]       stream_next = '0;

    sequenced_jitter_buffer dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_func              (func),
        .i_seq_num           (seq_num),
        .i_frame_handle      (frame_handle),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_frame_valid       (frame_valid),
        .o_out_handle        (out_handle),
        .o_dropped_count     (dropped_count),
        .o_at_cap            (at_cap),
        .o_cap_episode_count (cap_episode_count),
        .o_fill_level        (fill_level),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    sequenced_jitter_buffer_check checker_i (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_stall          (in_stall),
        .i_func              (func),
        .i_seq_num           (seq_num),
        .i_frame_handle      (frame_handle),
        .i_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .i_frame_valid       (frame_valid),
        .i_out_handle        (out_handle),
        .i_dropped_count     (dropped_count),
        .i_at_cap            (at_cap),
        .i_cap_episode_count (cap_episode_count),
        .i_fill_level        (fill_level),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .o_mismatches        (mismatches),
        .o_outstanding       (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run.
    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_idle(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 90);
    endfunction

    // Offer one word after a random gap; hold it until the block takes it.
    // Valid stays high on return so a back-to-back word needs no extra edge.
    task automatic send_word(input logic f, input logic [SEQ_W-1:0] s,
                             input logic [HANDLE_BITS-1:0] h);
        int g;
        g = pick_idle(tx_quiet);
        repeat (g) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        func         <= f;
        seq_num      <= s;
        frame_handle <= h;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid and wait until every predicted result word has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Registers change only with the block idle.
    task automatic configure(input logic [CFG_W-1:0] target, input logic [CFG_W-1:0] ceil);
        drain();
        write_reg(CFG_TARGET_FILL, target);
        write_reg(CFG_FILL_CEILING, ceil);
    endtask

    // Packet stream with network damage: mostly in-order pushes, plus losses,
    // early arrivals, late copies, duplicates and a little random noise.
    task automatic play_stream(input int n, input int pop_pct);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < pop_pct) begin
                send_word(FUNC_POP, $urandom, $urandom);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8) stream_next += 1;
                if (r < 70) begin
                    send_word(FUNC_PUSH, stream_next, $urandom);
                    stream_next += 1;
                end else if (r < 80) begin
                    send_word(FUNC_PUSH, stream_next + $urandom_range(1, 3), $urandom);
                end else if (r < 90) begin
                    send_word(FUNC_PUSH, stream_next - $urandom_range(1, 4), $urandom);
                end else if (r < 95) begin
                    send_word(FUNC_PUSH, stream_next, $urandom);
                end else begin
                    send_word(FUNC_PUSH, $urandom, $urandom);
                end
            end
        end
    endtask

    // Result side: alternate free and stalled runs, or honor a long hold-off.
    initial begin
        int  run_left;
        int  n;
        bit  stalled;
        out_stall = 1'b0;
        run_left  = 0;
        stalled   = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_cycles_req > 0) begin
                n = hold_cycles_req;
                hold_cycles_req = 0;
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
                run_left = 0;
                stalled  = 1'b0;
            end else begin
                if (run_left == 0) begin
                    stalled  = !stalled && !rx_quiet;
                    run_left = stalled ? 1 + pick_idle(1'b0) : $urandom_range(1, 12);
                end
                out_stall <= stalled;
                run_left--;
            end
        end
    end

    initial begin
        int k;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = FUNC_PUSH;
        seq_num      = '0;
        frame_handle = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_TARGET_FILL;
        cfg_data     = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Empty buffer with a zero target: the pop must not start playback.
        configure(0, 64);
        send_word(FUNC_POP, '0, '0);

        // Default levels: extremes of number and handle, silence before start,
        // start on the smallest number, a late push and an overwrite.
        configure(8, 64);
        send_word(FUNC_PUSH, '0, '0);
        send_word(FUNC_PUSH, '1, '1);
        send_word(FUNC_POP, '1, '1);
        for (k = 1; k <= 6; k++) send_word(FUNC_PUSH, k, $urandom);
        send_word(FUNC_POP, $urandom, $urandom);
        send_word(FUNC_POP, $urandom, $urandom);
        send_word(FUNC_PUSH, 0, $urandom);
        send_word(FUNC_PUSH, 3, $urandom);
        send_word(FUNC_POP, $urandom, $urandom);

        // Lower the ceiling under the fill: an overwrite evicts down to it,
        // then a push older than everything held evicts itself.
        configure(2, 3);
        send_word(FUNC_PUSH, 3, $urandom);
        send_word(FUNC_POP, $urandom, $urandom);
        send_word(FUNC_PUSH, 9, $urandom);
        send_word(FUNC_POP, $urandom, $urandom);
        send_word(FUNC_PUSH, 10, $urandom);
        send_word(FUNC_PUSH, 7, $urandom);

        // Zero ceiling: every push evicts everything, the newcomer included.
        configure(0, 0);
        send_word(FUNC_PUSH, 12, $urandom);
        send_word(FUNC_POP, $urandom, $urandom);

        stream_next = $urandom;

        // Defaults again; park the result side mid-phase so the block backs up.
        configure(8, 64);
        play_stream(35, 40);
        hold_cycles_req = 400;
        play_stream(35, 40);

        configure(0, 1);
        play_stream(50, 45);

        // Ceiling under the target, run without any idling.
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        configure(3, 2);
        play_stream(50, 45);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;

        // Full store, then oversized values that saturate.
        configure(64, 64);
        play_stream(80, 25);
        configure(127, 127);
        play_stream(50, 20);

        // Stream across the 32-bit wrap of the sequence number.
        configure(2, 10);
        stream_next = 32'hFFFF_FFF0 + $urandom_range(0, 8);
        tx_quiet = 1'b1;
        play_stream(60, 50);
        tx_quiet = 1'b0;

        // Pause the sender until every result is back, then resume.
        configure(16, 20);
        play_stream(30, 40);
        drain();
        play_stream(30, 40);

        configure(0, 0);
        play_stream(15, 30);

        // Trailing run of pops: empty the buffer and trip the miss limit.
        configure(5, 12);
        play_stream(60, 45);
        play_stream(70, 100);

        drain();
        repeat (150) @(negedge clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
